>>> design/aacl_pkg.sv
// Package: payload types, constants and the divider work item for the colour lerp.
package aacl_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_ONE = 17'h10000;
  localparam int PROD_W = 33;   // 17 x 16 products and the mixed alpha
  localparam int NUM_W = 50;    // weighted numerator plus half the divisor
  localparam int NCH = 3;

  typedef struct packed {
    logic [15:0] red_a;
    logic [15:0] green_a;
    logic [15:0] blue_a;
    logic [15:0] alpha_a;
    logic [15:0] red_b;
    logic [15:0] green_b;
    logic [15:0] blue_b;
    logic [15:0] alpha_b;
    logic [16:0] position;
  } item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } result_t;

  // One item on its way through the divider chain.
  typedef struct packed {
    logic                          gen;
    logic [NCH-1:0][NUM_W-1:0]     rem;
    logic [NCH-1:0][15:0]          quo;
    logic [PROD_W-1:0]             m;
    result_t                       res;
  } div_t;

endpackage

>>> design/alpha_aware_color_lerp.sv
// Top level: alpha-weighted interpolation of two RGBA colours, one item per clock.
// Usage:
//   Drive item_in and raise start; the item is taken at any edge where start is
//   high and busy is low. busy is always low: an item may be given every cycle.
//   Each result appears on result for exactly one cycle with done high; the
//   receiver cannot stall it, so it must take it in that cycle.
// Pipeline: four front stages, one divider cell per quotient bit, then the
//   output register that raises done.
// Throughput: one item per clock. The pipeline length is set by the row of
//   divider cells, each resolving one quotient bit of all three channels.
// Reset: rst (synchronous, active high) empties the pipeline; no results
//   appear until new items arrive. There is no configuration.
module alpha_aware_color_lerp #(
  parameter int CHANNEL_BITS = aacl_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aacl_pkg::item_t     item_in,
  output logic                done,
  output aacl_pkg::result_t   result
);

  logic [CHANNEL_BITS:0] cv;
  aacl_pkg::div_t        ci [CHANNEL_BITS+1];
  aacl_pkg::result_t     result_next;

  assign busy = 1'b0;

  aacl_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(start && !busy),
    .item_in(item_in),
    .out_valid(cv[0]),
    .out_item(ci[0])
  );

  for (genvar g = 0; g < CHANNEL_BITS; g++) begin : g_cell
    aacl_div_cell #(
      .K(CHANNEL_BITS - 1 - g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(cv[g]),
      .in_item(ci[g]),
      .out_valid(cv[g+1]),
      .out_item(ci[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[CHANNEL_BITS];
    end
  end

  always_comb begin
    result_next = ci[CHANNEL_BITS].res;
    // general case: take quotients, zero if the mixed alpha vanished
    if (ci[CHANNEL_BITS].gen) begin
      if (ci[CHANNEL_BITS].m == '0) begin
        result_next.red_out = '0;
        result_next.green_out = '0;
        result_next.blue_out = '0;
      end else begin
        result_next.red_out = ci[CHANNEL_BITS].quo[0];
        result_next.green_out = ci[CHANNEL_BITS].quo[1];
        result_next.blue_out = ci[CHANNEL_BITS].quo[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> design/aacl_front.sv
// Front stages: input register, weights and products, numerators and bypass results.
module aacl_front #(
  parameter int CHANNEL_BITS = aacl_pkg::CHANNEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  aacl_pkg::item_t   item_in,
  output logic              out_valid,
  output aacl_pkg::div_t    out_item
);

  localparam int PW = aacl_pkg::PROD_W;
  localparam int NW = aacl_pkg::NUM_W;
  localparam logic [15:0] MAXV = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

  // stage 0
  logic v0;
  logic [2:0][15:0] ca0, cb0;
  logic [15:0] aa0, ab0;
  logic [16:0] p0, q0;
  // stage 1
  logic v1, eq1, za1, zb1;
  logic [2:0][15:0] ca1, cb1;
  logic [15:0] aa1;
  logic [2:0][PW-1:0] pu1, pv1;
  logic [PW-1:0] wa1, wb1;
  // stage 2
  logic v2, gen2;
  logic [PW-1:0] m2;
  logic [2:0][NW-2:0] na2, nb2;
  aacl_pkg::result_t res2;
  // stage 2 combinational
  logic [PW-1:0] m_c;
  logic [PW-1:0] alpha_c;
  logic [2:0][PW:0] lerp_c;
  aacl_pkg::result_t res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: mask channels, clip position
    ca0[0] <= item_in.red_a & MAXV;
    ca0[1] <= item_in.green_a & MAXV;
    ca0[2] <= item_in.blue_a & MAXV;
    cb0[0] <= item_in.red_b & MAXV;
    cb0[1] <= item_in.green_b & MAXV;
    cb0[2] <= item_in.blue_b & MAXV;
    aa0 <= item_in.alpha_a & MAXV;
    ab0 <= item_in.alpha_b & MAXV;
    if (item_in.position > aacl_pkg::POS_ONE) begin
      p0 <= aacl_pkg::POS_ONE;
      q0 <= '0;
    end else begin
      p0 <= item_in.position;
      q0 <= aacl_pkg::POS_ONE - item_in.position;
    end
    // stage 1: weights and direct lerp products
    eq1 <= (aa0 == ab0);
    zb1 <= (ab0 == '0);
    za1 <= (aa0 == '0);
    ca1 <= ca0;
    cb1 <= cb0;
    aa1 <= aa0;
    wa1 <= PW'(q0) * PW'(aa0);
    wb1 <= PW'(p0) * PW'(ab0);
    for (int i = 0; i < 3; i++) begin
      pu1[i] <= PW'(q0) * PW'(ca0[i]);
      pv1[i] <= PW'(p0) * PW'(cb0[i]);
    end
    // stage 2: weighted numerators, bypass results
    m2 <= m_c;
    gen2 <= !eq1 && !zb1 && !za1;
    res2 <= res_c;
    for (int i = 0; i < 3; i++) begin
      na2[i] <= (NW-1)'(wa1) * (NW-1)'(ca1[i]);
      nb2[i] <= (NW-1)'(wb1) * (NW-1)'(cb1[i]);
    end
    // stage 3: form rounded-division numerators
    out_item.gen <= gen2;
    out_item.m <= m2;
    out_item.res <= res2;
    for (int i = 0; i < 3; i++) begin
      out_item.rem[i] <= NW'(na2[i]) + NW'(nb2[i]) + NW'(m2 >> 1);
      out_item.quo[i] <= '0;
    end
  end

  always_comb begin
    m_c = wa1 + wb1;
    alpha_c = (m_c + PW'(32768)) >> 16;
    for (int i = 0; i < 3; i++) begin
      lerp_c[i] = ((PW+1)'(pu1[i]) + (PW+1)'(pv1[i]) + (PW+1)'(32768)) >> 16;
    end
    if (eq1) begin
      res_c.red_out = lerp_c[0][15:0];
      res_c.green_out = lerp_c[1][15:0];
      res_c.blue_out = lerp_c[2][15:0];
      res_c.alpha_out = aa1;
    end else if (zb1) begin
      res_c.red_out = ca1[0];
      res_c.green_out = ca1[1];
      res_c.blue_out = ca1[2];
      res_c.alpha_out = alpha_c[15:0];
    end else if (za1) begin
      res_c.red_out = cb1[0];
      res_c.green_out = cb1[1];
      res_c.blue_out = cb1[2];
      res_c.alpha_out = alpha_c[15:0];
    end else begin
      res_c.red_out = '0;
      res_c.green_out = '0;
      res_c.blue_out = '0;
      res_c.alpha_out = alpha_c[15:0];
    end
  end

endmodule

>>> design/aacl_div_cell.sv
// Divider cell: settles one quotient bit for all three channels and hands on.
module aacl_div_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  aacl_pkg::div_t  in_item,
  output logic            out_valid,
  output aacl_pkg::div_t  out_item
);

  localparam int NW = aacl_pkg::NUM_W;

  logic [NW-1:0] dsh;
  aacl_pkg::div_t item_next;

  always_comb begin
    dsh = NW'(in_item.m) << K;
    item_next = in_item;
    for (int i = 0; i < aacl_pkg::NCH; i++) begin
      if (in_item.rem[i] >= dsh) begin
        item_next.rem[i] = in_item.rem[i] - dsh;
        item_next.quo[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

>>> verif/tb_alpha_aware_color_lerp.sv
// Testbench for the alpha-weighted colour lerp: random and directed items, local predictor.
module tb_alpha_aware_color_lerp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 5;
  localparam logic [16:0] ONE = 17'h10000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  aacl_pkg::item_t item_in = '0;
  logic done;
  aacl_pkg::result_t result;

  alpha_aware_color_lerp dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item_in(item_in), .done(done), .result(result)
  );

  aacl_pkg::item_t pending_items[$];
  aacl_pkg::result_t expected_colours[$];
  int mismatches = 0;
  bit feeding_done = 1'b0;
  bit idle_free = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] clamp16(logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] lerp16(logic [63:0] p, logic [63:0] u, logic [63:0] v);
    return clamp16(((65536 - p) * u + p * v + 32768) >> 16);
  endfunction

  function automatic logic [15:0] blend_chan(logic [63:0] wa, logic [63:0] ca,
                                             logic [63:0] wb, logic [63:0] cb,
                                             logic [63:0] m);
    if (m == 0) return 16'd0;
    return clamp16((wa * ca + wb * cb + m / 2) / m);
  endfunction

  function automatic aacl_pkg::result_t blend_colours(aacl_pkg::item_t it);
    aacl_pkg::result_t r;
    logic [63:0] p, q, aa, ab, wa, wb, m;
    p = (it.position > ONE) ? 64'(ONE) : 64'(it.position);
    q = 65536 - p;
    aa = it.alpha_a;
    ab = it.alpha_b;
    if (aa == ab) begin
      r.red_out = lerp16(p, it.red_a, it.red_b);
      r.green_out = lerp16(p, it.green_a, it.green_b);
      r.blue_out = lerp16(p, it.blue_a, it.blue_b);
      r.alpha_out = it.alpha_a;
    end else if (ab == 0) begin
      r.red_out = it.red_a;
      r.green_out = it.green_a;
      r.blue_out = it.blue_a;
      r.alpha_out = clamp16((q * aa + 32768) >> 16);
    end else if (aa == 0) begin
      r.red_out = it.red_b;
      r.green_out = it.green_b;
      r.blue_out = it.blue_b;
      r.alpha_out = clamp16((p * ab + 32768) >> 16);
    end else begin
      wa = q * aa;
      wb = p * ab;
      m = wa + wb;
      r.red_out = blend_chan(wa, it.red_a, wb, it.red_b, m);
      r.green_out = blend_chan(wa, it.green_a, wb, it.green_b, m);
      r.blue_out = blend_chan(wa, it.blue_a, wb, it.blue_b, m);
      r.alpha_out = clamp16((m + 32768) >> 16);
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic aacl_pkg::item_t random_item();
    aacl_pkg::item_t it;
    it.red_a = rand_chan();
    it.green_a = rand_chan();
    it.blue_a = rand_chan();
    it.red_b = rand_chan();
    it.green_b = rand_chan();
    it.blue_b = rand_chan();
    it.alpha_a = rand_chan();
    case ($urandom_range(0, 7))
      0: it.alpha_b = it.alpha_a;
      1: it.alpha_b = 16'd0;
      2: begin
        it.alpha_a = 16'd0;
        it.alpha_b = rand_chan();
      end
      default: it.alpha_b = rand_chan();
    endcase
    if (it.alpha_b == 0 && $urandom_range(0, 1)) it.alpha_b = rand_chan();
    case ($urandom_range(0, 7))
      0: it.position = 17'd0;
      1: it.position = ONE;
      2: it.position = 17'($urandom_range(65537, 131071));
      3: it.position = 17'($urandom_range(0, 3));
      default: it.position = 17'($urandom_range(0, 65536));
    endcase
    return it;
  endfunction

  function automatic aacl_pkg::item_t make_item(logic [15:0] ra, logic [15:0] ga,
                                                logic [15:0] ba, logic [15:0] aa,
                                                logic [15:0] rb, logic [15:0] gb,
                                                logic [15:0] bb, logic [15:0] ab,
                                                logic [16:0] pos);
    aacl_pkg::item_t it;
    it = '{ra, ga, ba, aa, rb, gb, bb, ab, pos};
    return it;
  endfunction

  // directed items, then random ones
  initial begin
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item('1, '1, '1, '1, '1, '1, '1, '1, ONE));
    pending_items.push_back(make_item('1, 0, '1, '1, 0, '1, 0, '1, 17'h08000));
    pending_items.push_back(make_item(100, 200, 300, 5000, 900, 800, 700, 0, 17'h04000));
    pending_items.push_back(make_item(100, 200, 300, 0, 900, 800, 700, 5000, 17'h0C000));
    pending_items.push_back(make_item(100, 200, 300, '1, 900, 800, 700, 0, ONE));
    pending_items.push_back(make_item(100, 200, 300, 0, 900, 800, 700, '1, 0));
    pending_items.push_back(make_item('1, 0, 1234, 1, 0, '1, 4321, '1, 17'h08000));
    pending_items.push_back(make_item('1, '1, '1, '1, '1, '1, '1, 1, 17'h00001));
    pending_items.push_back(make_item(0, '1, 7, 1, '1, 0, 9, 2, 17'h0FFFF));
    pending_items.push_back(make_item(1, 2, 3, 40000, 4, 5, 6, 20000, 17'h1FFFF));
    pending_items.push_back(make_item(1, 2, 3, 40000, 4, 5, 6, 20000, 17'h10001));
    pending_items.push_back(make_item('1, '1, '1, 0, 0, 0, 0, 0, 17'h18000));
    pending_items.push_back(make_item(16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF,
                                      16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000, 17'h0AAAA));
    pending_items.push_back(make_item(3, 3, 3, 7, 3, 3, 3, 7, 17'h00002));
    repeat (1150) pending_items.push_back(random_item());
  end

  // driver: present items at the falling edge, idle at random
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // taken at the last rising edge
      if (pending_items.size() > 0 && (idle_free || $urandom_range(0, 99) >= 32)) begin
        item_in <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (pending_items.size() == 0) feeding_done <= 1'b1;
      end
    end else if (!start) begin
      if (pending_items.size() > 0 && (idle_free || $urandom_range(0, 99) >= 32)) begin
        item_in <= pending_items.pop_front();
        start <= 1'b1;
      end else if (pending_items.size() == 0) begin
        feeding_done <= 1'b1;
      end
    end
  end

  // monitor: predict on acceptance, compare on done
  always @(posedge clk) begin
    aacl_pkg::result_t want;
    if (!rst) begin
      if (start && !busy) expected_colours.push_back(blend_colours(item_in));
      if (done) begin
        if (expected_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          want = expected_colours.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                       want.red_out, want.green_out, want.blue_out, want.alpha_out,
                       result.red_out, result.green_out, result.blue_out,
                       result.alpha_out);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // hold a stretch with no idling in the middle of the run
    wait (pending_items.size() < 700);
    idle_free = 1'b1;
    wait (pending_items.size() < 400);
    idle_free = 1'b0;
    wait (feeding_done && !start);
    wait (expected_colours.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("simulation failed");
    $finish;
  end
endmodule
